FILE: rtl/tpg_pkg.sv
// ----------------------------------------------------------------------------
// tpg_pkg
// shared types, register codes and defaults of the tone and pulse generator
// ----------------------------------------------------------------------------
package tpg_pkg;

  // defaults for the top level parameters
  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int NUM_PULSES_DEF      = 4;
  localparam int SAMPLE_BITS_DEF     = 16;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // fixed field widths
  localparam int PHASE_W    = 32;
  localparam int INDEX_W    = 24;
  localparam int IN_W       = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  // bit positions inside the mode register
  localparam int MODE_TONE = 0;
  localparam int MODE_ADD  = 1;

  // quarter-wave polynomial coefficients, q15
  localparam logic [15:0] SIN_A = 16'd51472;
  localparam logic [14:0] SIN_B = 15'd21024;
  localparam logic [11:0] SIN_C = 12'd2320;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP,
    REG_PHASE_OFFSET,
    REG_SINE_AMP,
    REG_MODE,
    REG_PULSE_0,
    REG_PULSE_1,
    REG_PULSE_2,
    REG_PULSE_3
  } reg_idx_t;

  // one pulse register, laid out as written on the config port
  typedef struct packed {
    logic [INDEX_W-1:0] start;
    logic [INDEX_W-1:0] len;
    logic signed [15:0] amp;
  } pulse_t;

  // tone and mode settings
  typedef struct packed {
    logic [PHASE_W-1:0] phase_step;
    logic [PHASE_W-1:0] phase_offset;
    logic [14:0]        sine_amp;
    logic [1:0]         mode;
  } cfg_t;

endpackage

FILE: rtl/tone_pulse_generator_unit.sv
// ----------------------------------------------------------------------------
// tone_pulse_generator_unit
// test-signal source: sine tone plus rectangular pulses plus optional input
//
// Each word on the in_ channel yields one sample on the out_ channel. in_tdata
// carries the existing channel sample, in_tuser the restart flag that clears
// the sample index and tone phase ahead of that word. out_tdata carries the
// saturated sample, out_tuser the clip flag. The cfg_ channel writes the tone,
// mode and pulse registers by index and is always ready; write it only while
// no word is in flight.
// Throughput is one word per clock while the output is not stalled. From in_
// accept to out_tvalid a word passes the four-entry queue, the input stage,
// the five polynomial multiplier stages and the output register.
// When out_tready is low with a word in the output register the back pipeline
// holds; the front keeps accepting until the queue fills, then drops in_tready.
// Reset clears the configuration registers, the phase accumulator and the
// sample index, and empties the queue and pipeline.
// ----------------------------------------------------------------------------
module tone_pulse_generator_unit #(
  parameter int TABLE_ADDR_BITS = tpg_pkg::TABLE_ADDR_BITS_DEF,
  parameter int NUM_PULSES      = tpg_pkg::NUM_PULSES_DEF,
  parameter int SAMPLE_BITS     = tpg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: existing_sample[15:0]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tpg_pkg::IN_W-1:0]        in_tdata,
  // in_tuser: restart[0]
  input  logic                            in_tuser,
  // out_tdata: sample_out[SAMPLE_BITS-1:0], zero fill above
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] out_tdata,
  // out_tuser: clipped[0]
  output logic                            out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tpg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tpg_pkg::*;

  localparam int Q_W = PHASE_W + NUM_PULSES + IN_W;

  cfg_t           cfg;
  pulse_t         pulse [NUM_PULSES];
  logic           q_push, q_pop, q_full, q_empty;
  logic [Q_W-1:0] q_wdata, q_rdata;

  tpg_regs #(
    .NUM_PULSES (NUM_PULSES)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .pulse     (pulse)
  );

  tpg_front #(
    .NUM_PULSES (NUM_PULSES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg),
    .pulse     (pulse),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  tpg_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .data_in  (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .data_out (q_rdata),
    .empty    (q_empty)
  );

  tpg_back #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .NUM_PULSES      (NUM_PULSES),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_data     (q_rdata),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .cfg        (cfg),
    .pulse      (pulse),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // queue never reports full and empty at once
  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue full and empty together");

  // back never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

  // a stalled output freezes the back pipeline
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !q_pop)
    else $error("queue popped while output stalled");

  // reset leaves no sample pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

FILE: rtl/tpg_regs.sv
// ----------------------------------------------------------------------------
// tpg_regs
// configuration register file, written through the cfg channel
// ----------------------------------------------------------------------------
module tpg_regs #(
  parameter int NUM_PULSES = tpg_pkg::NUM_PULSES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tpg_pkg::CFG_DATA_W-1:0]  cfg_data,
  output tpg_pkg::cfg_t                   cfg,
  output tpg_pkg::pulse_t                 pulse [NUM_PULSES]
);
  import tpg_pkg::*;

  cfg_t   cfg_r;
  pulse_t pulse_r [NUM_PULSES];
  logic   wr;

  // writes are always taken
  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // tone and mode registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr) begin
      case (cfg_index)
        REG_PHASE_STEP:   cfg_r.phase_step   <= cfg_data[PHASE_W-1:0];
        REG_PHASE_OFFSET: cfg_r.phase_offset <= cfg_data[PHASE_W-1:0];
        REG_SINE_AMP:     cfg_r.sine_amp     <= cfg_data[14:0];
        REG_MODE:         cfg_r.mode         <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // pulse registers, only those in use are kept
  for (genvar k = 0; k < NUM_PULSES; k++) begin : g_pulse
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pulse_r[k] <= '0;
      end else if (wr && cfg_index == CFG_IDX_W'(REG_PULSE_0) + CFG_IDX_W'(k)) begin
        pulse_r[k] <= pulse_t'(cfg_data);
      end
    end
  end

  assign cfg   = cfg_r;
  assign pulse = pulse_r;

endmodule

FILE: rtl/tpg_front.sv
// ----------------------------------------------------------------------------
// tpg_front
// accepts input words, keeps phase and sample index, flags active pulses
// ----------------------------------------------------------------------------
module tpg_front #(
  parameter int NUM_PULSES = tpg_pkg::NUM_PULSES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [tpg_pkg::IN_W-1:0] in_tdata,
  input  logic                     in_tuser,
  input  tpg_pkg::cfg_t            cfg,
  input  tpg_pkg::pulse_t          pulse [NUM_PULSES],
  output logic                     q_push,
  output logic [tpg_pkg::PHASE_W+NUM_PULSES+tpg_pkg::IN_W-1:0] q_data,
  input  logic                     q_full
);
  import tpg_pkg::*;

  logic [PHASE_W-1:0]    phase_acc_r, phase_acc_nxt, phase_cur, phase_sel;
  logic [INDEX_W-1:0]    index_r, index_nxt, index_cur;
  logic [NUM_PULSES-1:0] hit;
  logic [IN_W-1:0]       exist;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  // restart clears index and phase ahead of this sample
  always_comb begin
    phase_cur     = in_tuser ? '0 : phase_acc_r;
    index_cur     = in_tuser ? '0 : index_r;
    phase_sel     = phase_cur + cfg.phase_offset;
    phase_acc_nxt = phase_cur + cfg.phase_step;
    index_nxt     = index_cur + INDEX_W'(1);
    exist         = cfg.mode[MODE_ADD] ? in_tdata : '0;
  end

  // pulse windows, end computed one bit wider so it never wraps
  for (genvar k = 0; k < NUM_PULSES; k++) begin : g_hit
    logic [INDEX_W:0] stop;
    assign stop   = {1'b0, pulse[k].start} + {1'b0, pulse[k].len};
    assign hit[k] = (index_cur >= pulse[k].start) && ({1'b0, index_cur} < stop);
  end

  assign q_data = {exist, hit, phase_sel};

  // sample state advances once per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
      index_r     <= '0;
    end else if (q_push) begin
      phase_acc_r <= phase_acc_nxt;
      index_r     <= index_nxt;
    end
  end

endmodule

FILE: rtl/tpg_queue.sv
// ----------------------------------------------------------------------------
// tpg_queue
// small first-in first-out queue between front and back
// ----------------------------------------------------------------------------
module tpg_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tpg_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] data_in,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] data_out,
  output logic             empty
);
  import tpg_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = count_r == CNT_W'(DEPTH);
  assign empty    = count_r == '0;
  assign data_out = slot_r[rd_ptr_r];

  // pointer wrap and fill level
  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_nxt;
      if (pop)  rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= data_in;
    end
  end

endmodule

FILE: rtl/tpg_back.sv
// ----------------------------------------------------------------------------
// tpg_back
// sine polynomial pipeline, sum with pulses and input, saturation, output
// ----------------------------------------------------------------------------
module tpg_back #(
  parameter int TABLE_ADDR_BITS = tpg_pkg::TABLE_ADDR_BITS_DEF,
  parameter int NUM_PULSES      = tpg_pkg::NUM_PULSES_DEF,
  parameter int SAMPLE_BITS     = tpg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [tpg_pkg::PHASE_W+NUM_PULSES+tpg_pkg::IN_W-1:0] q_data,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  tpg_pkg::cfg_t        cfg,
  input  tpg_pkg::pulse_t      pulse [NUM_PULSES],
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] out_tdata,
  output logic                 out_tuser
);
  import tpg_pkg::*;

  localparam int OUT_W   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int SUM_W   = (SAMPLE_BITS + 1 > 20) ? SAMPLE_BITS + 1 : 20;
  localparam int LOW_CUT = 17 - TABLE_ADDR_BITS;
  localparam logic signed [SUM_W-1:0] MAXV = SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] MINV = ~MAXV;

  logic                    en;
  logic [PHASE_W-1:0]      phase;
  logic [NUM_PULSES-1:0]   hit;
  logic signed [IN_W-1:0]  exist;
  logic [14:0]             x15;
  logic [15:0]             x_s0;
  logic signed [SUM_W-1:0] side_s0;

  logic                    v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [15:0]             x1_r, x2_r, x3_r, x4_r;
  logic [15:0]             sq2_r, sq3_r, sq_nxt;
  logic [14:0]             t3_r, t3_nxt;
  logic [15:0]             t4_r, t4_nxt;
  logic [15:0]             y5_r, y5_nxt, mag;
  logic                    neg1_r, neg2_r, neg3_r, neg4_r, neg5_r;
  logic signed [SUM_W-1:0] side1_r, side2_r, side3_r, side4_r, side5_r, side6_r;
  logic signed [16:0]      tone6_r, tone6_nxt;
  logic [31:0]             p2, p3, p4, p5, p6;
  logic signed [SUM_W-1:0] sum, sat;
  logic                    clip_nxt;
  logic                    out_valid_r, clip_r;
  logic [OUT_W-1:0]        out_data_r, out_data_nxt;

  // the whole pipeline moves when the output register is free or emptying
  assign en    = !out_valid_r || out_tready;
  assign q_pop = en && !q_empty;

  // unpack the queued word, quadrant mirror, and sum of input and pulses
  always_comb begin
    phase   = q_data[PHASE_W-1:0];
    hit     = q_data[PHASE_W +: NUM_PULSES];
    exist   = $signed(q_data[PHASE_W+NUM_PULSES +: IN_W]);
    x15     = (phase[29:15] >> LOW_CUT) << LOW_CUT;
    x_s0    = phase[30] ? 16'd32768 - {1'b0, x15} : {1'b0, x15};
    side_s0 = SUM_W'(exist);
    for (int k = 0; k < NUM_PULSES; k++) begin
      if (hit[k]) side_s0 = side_s0 + SUM_W'(pulse[k].amp);
    end
  end

  // polynomial steps, one product per stage
  always_comb begin
    p2     = 32'(x1_r) * 32'(x1_r);
    sq_nxt = 16'(p2 >> 15);
    p3     = 32'(SIN_C) * 32'(sq2_r);
    t3_nxt = 15'(16'(SIN_B) - 16'(p3 >> 15));
    p4     = 32'(t3_r) * 32'(sq3_r);
    t4_nxt = SIN_A - 16'(p4 >> 15);
    p5     = 32'(t4_r) * 32'(x4_r);
    y5_nxt = 16'(p5 >> 15);
    p6     = 32'(cfg.sine_amp) * 32'(y5_r) + 32'd16384;
    mag    = 16'(p6 >> 15);
    if (!cfg.mode[MODE_TONE]) begin
      tone6_nxt = '0;
    end else if (neg5_r) begin
      tone6_nxt = -$signed({1'b0, mag});
    end else begin
      tone6_nxt = $signed({1'b0, mag});
    end
  end

  // final sum and saturation
  always_comb begin
    sum      = side6_r + SUM_W'(tone6_r);
    clip_nxt = (sum > MAXV) || (sum < MINV);
    if (sum > MAXV) begin
      sat = MAXV;
    end else if (sum < MINV) begin
      sat = MINV;
    end else begin
      sat = sum;
    end
    out_data_nxt = OUT_W'(sat[SAMPLE_BITS-1:0]);
  end

  // stage valid bits and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= !q_empty;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      x1_r       <= x_s0;
      neg1_r     <= phase[31];
      side1_r    <= side_s0;
      x2_r       <= x1_r;
      sq2_r      <= sq_nxt;
      neg2_r     <= neg1_r;
      side2_r    <= side1_r;
      x3_r       <= x2_r;
      sq3_r      <= sq2_r;
      t3_r       <= t3_nxt;
      neg3_r     <= neg2_r;
      side3_r    <= side2_r;
      x4_r       <= x3_r;
      t4_r       <= t4_nxt;
      neg4_r     <= neg3_r;
      side4_r    <= side3_r;
      y5_r       <= y5_nxt;
      neg5_r     <= neg4_r;
      side5_r    <= side4_r;
      tone6_r    <= tone6_nxt;
      side6_r    <= side5_r;
      out_data_r <= out_data_nxt;
      clip_r     <= clip_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = clip_r;

endmodule

FILE: tb/tpg_sample_checker.sv
// ----------------------------------------------------------------------------
// tpg_sample_checker
// watches the in_, out_ and cfg_ channels of the tone and pulse generator,
// keeps its own copy of the registers, phase and sample index, predicts one
// sample word per accepted input word and compares each output word, field by
// field, with the oldest prediction
// ----------------------------------------------------------------------------
module tpg_sample_checker #(
  parameter int OUT_W = ((tpg_pkg::SAMPLE_BITS_DEF + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [tpg_pkg::IN_W-1:0]       in_tdata,
  input  logic                           in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [OUT_W-1:0]               out_tdata,
  input  logic                           out_tuser,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpg_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatch_count,
  output int                             words_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  import tpg_pkg::*;

  localparam int     TABLE_BITS = TABLE_ADDR_BITS_DEF;
  localparam int     PULSES     = NUM_PULSES_DEF;
  localparam int     SBITS      = SAMPLE_BITS_DEF;
  localparam longint SAMPLE_MAX = (longint'(1) << (SBITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam longint Q15_ONE    = 32768;
  localparam longint Q15_HALF   = 16384;
  localparam int     Q15_SHIFT  = 15;

  // one predicted output word
  typedef struct packed {
    logic [SBITS-1:0] level;
    logic             clipped;
  } sample_word_t;

  cfg_t               tone_cfg;
  pulse_t             pulse_reg [4];
  logic [PHASE_W-1:0] phase_acc;
  logic [INDEX_W-1:0] sample_idx;
  sample_word_t       owed_q [$];
  int                 errors = 0;

  // signed tone level for one phase, quarter-wave polynomial in q15
  function automatic longint sine_level(logic [PHASE_W-1:0] phase);
    logic [PHASE_W-1:0] point;
    logic [1:0]         quad;
    longint             x, x2, t, y, mag;
    point = (phase >> (PHASE_W - TABLE_BITS)) << (PHASE_W - TABLE_BITS);
    quad  = point[PHASE_W-1 -: 2];
    x     = longint'(point[PHASE_W-3:0]) >> Q15_SHIFT;
    // mirror in the second and fourth quadrants
    if (quad[0]) x = Q15_ONE - x;
    x2  = (x * x) >> Q15_SHIFT;
    t   = (longint'(SIN_C) * x2) >> Q15_SHIFT;
    t   = longint'(SIN_B) - t;
    t   = (t * x2) >> Q15_SHIFT;
    t   = longint'(SIN_A) - t;
    y   = (t * x) >> Q15_SHIFT;
    mag = (longint'(tone_cfg.sine_amp) * y + Q15_HALF) >> Q15_SHIFT;
    return quad[1] ? -mag : mag;
  endfunction

  // predicted word for one input word, advances phase and sample index
  function automatic sample_word_t next_sample(logic [IN_W-1:0] existing, logic restart);
    longint       total;
    longint       idx;
    sample_word_t w;
    w = '0;
    total = 0;
    if (restart) begin
      phase_acc  = '0;
      sample_idx = '0;
    end
    idx = longint'(sample_idx);
    if (tone_cfg.mode[MODE_TONE]) total += sine_level(phase_acc + tone_cfg.phase_offset);
    // pulse windows never wrap past the top of the index range
    for (int k = 0; k < PULSES; k++) begin
      if (idx >= longint'(pulse_reg[k].start) &&
          idx < longint'(pulse_reg[k].start) + longint'(pulse_reg[k].len))
        total += longint'($signed(pulse_reg[k].amp));
    end
    if (tone_cfg.mode[MODE_ADD]) total += longint'($signed(existing));
    // saturate
    if (total > SAMPLE_MAX) begin
      total     = SAMPLE_MAX;
      w.clipped = 1'b1;
    end
    if (total < SAMPLE_MIN) begin
      total     = SAMPLE_MIN;
      w.clipped = 1'b1;
    end
    w.level    = total[SBITS-1:0];
    phase_acc  = phase_acc + tone_cfg.phase_step;
    sample_idx = sample_idx + 1'b1;
    return w;
  endfunction

  always @(posedge clk) begin : track
    sample_word_t want;
    if (!rst_n) begin
      tone_cfg   = '0;
      phase_acc  = '0;
      sample_idx = '0;
      for (int k = 0; k < 4; k++) pulse_reg[k] = '0;
      owed_q.delete();
    end else begin
      // register writes, unknown indexes ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PHASE_STEP:   tone_cfg.phase_step   = cfg_data[PHASE_W-1:0];
          REG_PHASE_OFFSET: tone_cfg.phase_offset = cfg_data[PHASE_W-1:0];
          REG_SINE_AMP:     tone_cfg.sine_amp     = cfg_data[14:0];
          REG_MODE:         tone_cfg.mode         = cfg_data[1:0];
          REG_PULSE_0:      pulse_reg[0]          = cfg_data;
          REG_PULSE_1:      pulse_reg[1]          = cfg_data;
          REG_PULSE_2:      pulse_reg[2]          = cfg_data;
          REG_PULSE_3:      pulse_reg[3]          = cfg_data;
          default: ;
        endcase
      end
      // output word against the oldest prediction
      if (out_tvalid && out_tready) begin
        if (owed_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected output word, expected none, got sample %0d clipped %0b",
                   $time, $signed(out_tdata[SBITS-1:0]), out_tuser);
        end else begin
          want = owed_q.pop_front();
          if (out_tdata[SBITS-1:0] !== want.level) begin
            errors++;
            $display("%0t: sample mismatch, expected %0d, got %0d", $time,
                     $signed(want.level), $signed(out_tdata[SBITS-1:0]));
          end
          if (out_tuser !== want.clipped) begin
            errors++;
            $display("%0t: clip flag mismatch, expected %0b, got %0b", $time,
                     want.clipped, out_tuser);
          end
        end
      end
      // input word, predict its sample
      if (in_tvalid && in_tready)
        owed_q.insert(owed_q.size(), next_sample(in_tdata, in_tuser));
    end
    words_owed     <= owed_q.size();
    mismatch_count <= errors;
  end

endmodule

FILE: tb/tb_tone_pulse_generator_unit.sv
// ----------------------------------------------------------------------------
// tb_tone_pulse_generator_unit
// drives the tone and pulse generator through a directed burst and several
// random register settings, with random stalls on both channels and one long
// output hold-off, while the checker predicts and compares every sample word
// ----------------------------------------------------------------------------
module tb_tone_pulse_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tpg_pkg::*;

  localparam int OUT_W          = ((SAMPLE_BITS_DEF + 7) / 8) * 8;
  localparam int LATENCY        = 7;
  localparam int DIRECTED_WORDS = 24;
  localparam int PHASE_WORDS    = 100;
  localparam int NUM_PHASES     = 9;
  localparam int IDLE_PCT       = 15;
  localparam int HOLD_AT        = 150;
  localparam int HOLD_CYCLES    = 60;
  localparam int STALL_LIMIT    = 2000;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = CFG_IDX_W'(REG_PULSE_3) + 1'b1;
  localparam logic [INDEX_W-1:0]   INDEX_MAX        = '1;
  localparam logic [IN_W-1:0]      LEVEL_MAX        = 16'h7FFF;
  localparam logic [IN_W-1:0]      LEVEL_MIN        = 16'h8000;
  localparam logic [14:0]          SINE_AMP_MAX     = '1;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [OUT_W-1:0]      out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int     mismatch_count;
  int     words_owed;
  int     idle_pct   = 0;
  int     words_sent = 0;
  bit     hold_done  = 1'b0;
  pulse_t pulses [4];

  tone_pulse_generator_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  tpg_sample_checker #(.OUT_W(OUT_W)) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .words_owed     (words_owed)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one register write, valid stays up for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // write every register, junk in the unused upper bits, plus an unknown index
  task automatic apply_settings(input logic [PHASE_W-1:0] inc, input logic [PHASE_W-1:0] offset,
                                input logic [14:0] amp, input logic [1:0] mode_bits);
    logic [CFG_DATA_W-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_PHASE_STEP, {junk[63:32], inc});
    write_reg(REG_PHASE_OFFSET, {junk[31:0], offset});
    write_reg(REG_SINE_AMP, {junk[63:15], amp});
    write_reg(REG_MODE, {junk[63:2], mode_bits});
    for (int k = 0; k < 4; k++) write_reg(CFG_IDX_W'(REG_PULSE_0 + k), pulses[k]);
    write_reg(CFG_IDX_W'($urandom_range(int'(REG_FIRST_UNUSED), (1 << CFG_IDX_W) - 1)), junk);
    cfg_valid <= 1'b0;
  endtask

  // one input word, sometimes followed by a random gap
  task automatic send_word(input logic [IN_W-1:0] existing, input logic restart);
    in_tvalid <= 1'b1;
    in_tdata  <= existing;
    in_tuser  <= restart;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // stop sending and wait for every predicted word to come out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
  endtask

  function automatic pulse_t random_pulse();
    pulse_t p;
    case ($urandom_range(0, 9))
      0:       p.start = '0;
      1:       p.start = INDEX_MAX;
      default: p.start = INDEX_W'($urandom_range(0, 400));
    endcase
    case ($urandom_range(0, 9))
      0:       p.len = '0;
      1:       p.len = INDEX_MAX;
      2:       p.len = INDEX_W'(1);
      default: p.len = INDEX_W'($urandom_range(1, 150));
    endcase
    case ($urandom_range(0, 5))
      0:       p.amp = LEVEL_MAX;
      1:       p.amp = LEVEL_MIN;
      default: p.amp = IN_W'($urandom);
    endcase
    return p;
  endfunction

  function automatic logic [IN_W-1:0] random_level();
    case ($urandom_range(0, 9))
      0:       return LEVEL_MAX;
      1:       return LEVEL_MIN;
      default: return IN_W'($urandom);
    endcase
  endfunction

  // receiver: random stalls, one long hold-off so the queue fills
  initial begin
    @(posedge clk);
    forever begin
      if (!hold_done && words_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // watchdog on cycles without any accepted word
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tone_pulse_generator_unit test failed");
    $finish;
  end

  // stimulus and verdict
  initial begin
    logic [PHASE_W-1:0] inc, offset;
    logic [14:0]        amp;
    logic [1:0]         mode_bits;
    logic [IN_W-1:0]    level;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: sixteenth-turn steps over every quadrant at full tone,
    // full-scale inputs for clipping both ways, separate and endless pulses,
    // a pulse beyond the reachable index range, restarts back to back
    pulses[0] = '{start: '0, len: INDEX_W'(2), amp: LEVEL_MAX};
    pulses[1] = '{start: INDEX_W'(4), len: INDEX_W'(3), amp: LEVEL_MIN};
    pulses[2] = '{start: INDEX_W'(8), len: INDEX_MAX, amp: '1};
    pulses[3] = '{start: INDEX_MAX, len: INDEX_MAX, amp: IN_W'(1)};
    apply_settings(32'h1000_0000, '0, SINE_AMP_MAX, 2'b11);
    for (int i = 0; i < DIRECTED_WORDS; i++) begin
      if (i < 16) level = (i % 2 == 0) ? LEVEL_MAX : LEVEL_MIN;
      else begin
        case (i % 4)
          0:       level = '0;
          1:       level = '1;
          2:       level = IN_W'(1);
          default: level = IN_W'($urandom);
        endcase
      end
      send_word(level, i == 0 || i == 16 || i == 20 || i == 21);
    end
    drain();

    // random phases, first ones at the register extremes and each mode
    for (int p = 1; p < NUM_PHASES; p++) begin
      idle_pct = (p == NUM_PHASES - 1 || p % 3 == 0) ? 0 : IDLE_PCT;
      case ($urandom_range(0, 4))
        0:       inc = '0;
        1:       inc = '1;
        2:       inc = $urandom_range(0, 1 << 24);
        default: inc = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0:       offset = '0;
        1:       offset = '1;
        default: offset = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0:       amp = '0;
        1:       amp = SINE_AMP_MAX;
        default: amp = 15'($urandom);
      endcase
      mode_bits = (p <= 4) ? 2'(p) : 2'($urandom);
      for (int k = 0; k < 4; k++) pulses[k] = random_pulse();
      if (p == 1) begin
        inc    = '1;
        offset = '1;
        amp    = SINE_AMP_MAX;
        for (int k = 0; k < 4; k++) pulses[k] = '{start: '0, len: INDEX_MAX, amp: LEVEL_MAX};
      end else if (p == 2) begin
        inc    = '0;
        offset = '0;
        amp    = '0;
        for (int k = 0; k < 4; k++) pulses[k] = '{start: '0, len: '0, amp: LEVEL_MIN};
      end
      apply_settings(inc, offset, amp, mode_bits);
      for (int i = 0; i < PHASE_WORDS; i++)
        send_word(random_level(), $urandom_range(0, 39) == 0);
      drain();
    end

    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0 && words_owed == 0)
      $display("tone_pulse_generator_unit test passed");
    else
      $display("tone_pulse_generator_unit test failed");
    $finish;
  end

endmodule
